// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// holds operation and status codes, controller states and the command bundle
// ----------------------------------------------------------------------------
package spq_pkg;

  parameter int unsigned SPQ_DEPTH = 16;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 5;

  // operation selector carried on the input tuser
  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } spq_op_t;

  // result status
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } spq_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture the input item
    logic exec;  // update the entries and the result register
  } spq_cmd_t;

endpackage

// ===== hdl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl: handshake and sequencing controller
// accepts one item, runs the update in S_EXEC, holds the result until taken
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output spq_pkg::spq_cmd_t  cmd
);
  import spq_pkg::*;

  spq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // result register frees up in the same cycle it is taken
        in_tready = !out_valid_r || out_tready;
        if (in_tvalid && in_tready) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.exec || (out_valid_r && !out_tready);
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== hdl/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath: row of sorted entry cells with parallel compare and shift
// each cell compares against the new priority and picks its next contents
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int unsigned DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spq_pkg::spq_cmd_t                 cmd,
  input  logic                              in_op,
  input  logic signed [spq_pkg::DATA_W-1:0] in_data,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_prio,
  output logic signed [spq_pkg::DATA_W-1:0] res_data,
  output logic [spq_pkg::STATUS_W-1:0]      res_status,
  output logic [spq_pkg::FILL_W-1:0]        res_fill
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // captured item
  spq_op_t                  op_r;
  logic signed [DATA_W-1:0] din_r;
  logic signed [PRIO_W-1:0] pin_r;

  // entry cells, head at index zero
  logic signed [DATA_W-1:0] data_r   [DEPTH];
  logic signed [PRIO_W-1:0] prio_r   [DEPTH];
  logic signed [DATA_W-1:0] data_nxt [DEPTH];
  logic signed [PRIO_W-1:0] prio_nxt [DEPTH];
  logic [CW-1:0]            count_r, count_nxt;

  // neighbor taps and compare flags
  logic signed [DATA_W-1:0] dn_data [DEPTH];
  logic signed [PRIO_W-1:0] dn_prio [DEPTH];
  logic signed [DATA_W-1:0] up_data [DEPTH];
  logic signed [PRIO_W-1:0] up_prio [DEPTH];
  logic [DEPTH-1:0]         ge;
  logic [DEPTH-1:0]         prev_ge;

  logic        do_enq, do_deq;
  spq_status_t status_nxt;

  // result register
  logic signed [DATA_W-1:0] res_data_r;
  spq_status_t              res_status_r;
  logic [FILL_W-1:0]        res_fill_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= spq_op_t'(in_op);
      din_r <= in_data;
      pin_r <= in_prio;
    end
  end

  assign do_enq = cmd.exec && (op_r == OP_ENQ) && (count_r < CW'(DEPTH));
  assign do_deq = cmd.exec && (op_r == OP_DEQ) && (count_r != '0);

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      // stored entries are sorted, so ge forms a prefix of the row
      assign ge[g] = (CW'(g) < count_r) && (prio_r[g] >= pin_r);

      if (g == 0) begin : g_head
        assign prev_ge[g] = 1'b1;
        assign dn_data[g] = din_r;
        assign dn_prio[g] = pin_r;
      end else begin : g_body
        assign prev_ge[g] = ge[g-1];
        assign dn_data[g] = data_r[g-1];
        assign dn_prio[g] = prio_r[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
        assign up_data[g] = data_r[g];
        assign up_prio[g] = prio_r[g];
      end else begin : g_inner
        assign up_data[g] = data_r[g+1];
        assign up_prio[g] = prio_r[g+1];
      end

      always_comb begin
        data_nxt[g] = data_r[g];
        prio_nxt[g] = prio_r[g];
        if (do_deq) begin
          data_nxt[g] = up_data[g];
          prio_nxt[g] = up_prio[g];
        end else if (do_enq) begin
          if (prev_ge[g] && !ge[g]) begin
            // insertion slot
            data_nxt[g] = din_r;
            prio_nxt[g] = pin_r;
          end else if (!prev_ge[g]) begin
            data_nxt[g] = dn_data[g];
            prio_nxt[g] = dn_prio[g];
          end
        end
      end

      always_ff @(posedge clk) begin
        data_r[g] <= data_nxt[g];
        prio_r[g] <= prio_nxt[g];
      end
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (do_enq) begin
      count_nxt = count_r + CW'(1);
    end else if (do_deq) begin
      count_nxt = count_r - CW'(1);
    end
    if (op_r == OP_ENQ) begin
      status_nxt = do_enq ? ST_OK : ST_FULL;
    end else begin
      status_nxt = do_deq ? ST_OK : ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_data_r   <= do_deq ? data_r[0] : '0;
      res_status_r <= status_nxt;
      res_fill_r   <= FILL_W'(count_nxt);
    end
  end

  assign res_data   = res_data_r;
  assign res_status = res_status_r;
  assign res_fill   = res_fill_r;

endmodule

// ===== hdl/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: sorted-list priority queue with stream ports
// entries held in falling priority order, equal priorities leave in order
// ----------------------------------------------------------------------------
// usage
//   input channel in_*: in_tuser selects the operation (0 enqueue, 1 dequeue),
//   in_tdata carries the data word and priority for an enqueue; both are
//   ignored on a dequeue except the operation
//   result channel out_*: one item per input item, carrying the dequeued
//   data (zero otherwise), a status code and the fill count afterwards
//   timing: an accepted item is captured, the entry row updates in S_EXEC and
//   the result is registered; one item is in flight at a time, so a new item
//   is taken only after the controller is back in S_IDLE
//   the update works on all cells at once for any fill: every cell compares its
//   priority with the new one in parallel and shifts or loads in place
//   reset: synchronous, active low; the queue comes up empty and no result
//   is pending
//   stall: a result waits in the output register while out_tready is low;
//   a new item is taken only once that result is gone or leaving
//   errors: dequeue on empty and enqueue on full report a status and leave
//   the entries untouched
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int unsigned DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [0:0]  in_tuser,   // [0] operation
  input  logic [47:0] in_tdata,   // [31:0] data_in, [47:32] priority_in
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] data_out, [33:32] status,
                                  // [38:34] fill_count, [39] zero
);
  import spq_pkg::*;

  spq_cmd_t                 cmd;
  logic signed [DATA_W-1:0] res_data;
  logic [STATUS_W-1:0]      res_status;
  logic [FILL_W-1:0]        res_fill;

  // sequencing and handshakes
  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // entry row and result register
  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_op      (in_tuser[0]),
    .in_data    (in_tdata[31:0]),
    .in_prio    (in_tdata[47:32]),
    .res_data   (res_data),
    .res_status (res_status),
    .res_fill   (res_fill)
  );

  // pack the result item, padding bit stays low
  assign out_tdata = {1'b0, res_fill, res_status, res_data};

  // full report only when the row really is at capacity
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

  // one item at a time: the controller closes the input right after a take
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is still in flight");

  // every accepted item shows its result once the S_EXEC update has run
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> ##2 out_tvalid)
    else $error("result missing after accepted item");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[33:32] == ST_FULL)) |-> (out_tdata[38:34] == FULL_FILL))
    else $error("full status with queue not at capacity");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[33:32] == ST_EMPTY)) |->
      ((out_tdata[31:0] == '0) && (out_tdata[38:34] == '0)))
    else $error("empty status with data or nonzero fill");

endmodule
